/* src/sfla_pkg.sv */
package sfla_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_LOST  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_F_RD,
    S_F_CHK,
    S_F_DEC,
    S_SH_RD,
    S_SH_WR,
    S_INS_RD,
    S_INS_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [31:0] size;
  } in_item_t;

  typedef struct packed {
    logic [31:0] alloc_addr;
    logic [1:0]  status;
    logic [31:0] total_free;
    logic [8:0]  peak_entries;
    logic [31:0] lost_count;
    logic [31:0] lost_bytes;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } region_t;

  typedef struct packed {
    logic    we;
    region_t wdata;
  } mem_wr_t;

endpackage

/* src/sfla_mem.sv */
module sfla_mem #(
  parameter int TABLE_ENTRIES = sfla_pkg::TABLE_ENTRIES_DEF,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk,
  input  sfla_pkg::mem_wr_t wr,
  input  logic [IW-1:0]    waddr,
  input  logic [IW-1:0]    raddr,
  output sfla_pkg::region_t rdata
);
  import sfla_pkg::*;

  region_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/sfla_ctrl.sv */
module sfla_ctrl #(
  parameter int TABLE_ENTRIES = sfla_pkg::TABLE_ENTRIES_DEF,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  sfla_pkg::in_item_t req,
  output logic              res_valid,
  input  logic              res_take,
  output sfla_pkg::out_item_t res,
  output logic [CW-1:0]     entry_count,
  output sfla_pkg::mem_wr_t mem_wr,
  output logic [IW-1:0]     mem_waddr,
  output logic [IW-1:0]     mem_raddr,
  input  sfla_pkg::region_t mem_rdata
);
  import sfla_pkg::*;

  state_e        state_r, state_nxt;
  in_item_t      req_r, req_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] peak_r, peak_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  region_t       prev_r, prev_nxt;
  region_t       next_r, next_nxt;
  logic          has_prev_r, has_prev_nxt;
  logic          has_next_r, has_next_nxt;
  logic [31:0]   total_r, total_nxt;
  logic [31:0]   lost_cnt_r, lost_cnt_nxt;
  logic [31:0]   lost_bytes_r, lost_bytes_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  status_e       res_status_r, res_status_nxt;

  logic          fit, beyond, at_end, prev_join, next_join, shift_more, not_full, ins_more;
  logic [31:0]   new_len;
  logic [CW:0]   idx_inc;
  logic [CW-1:0] cnt_inc;

  assign new_len    = mem_rdata.len - req_r.size;
  assign fit        = mem_rdata.len >= req_r.size;
  assign beyond     = mem_rdata.start > req_r.addr;
  assign at_end     = idx_r == cnt_r;
  assign prev_join  = has_prev_r && ((prev_r.start + prev_r.len) == req_r.addr);
  assign next_join  = has_next_r && ((req_r.addr + req_r.size) == next_r.start);
  assign idx_inc    = {1'b0, idx_r} + 1'b1;
  assign shift_more = idx_inc < {1'b0, cnt_r};
  assign not_full   = cnt_r < CW'(TABLE_ENTRIES);
  assign ins_more   = idx_r > CW'(pos_r);
  assign cnt_inc    = cnt_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          state_nxt = (req.kind == KIND_FREE) ? S_F_RD : S_A_RD;
        end
      end
      S_A_RD:   state_nxt = at_end ? S_DONE : S_A_CHK;
      S_A_CHK: begin
        if (fit) begin
          state_nxt = (new_len == 32'd0) ? S_SH_RD : S_DONE;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_F_RD:   state_nxt = at_end ? S_F_DEC : S_F_CHK;
      S_F_CHK:  state_nxt = beyond ? S_F_DEC : S_F_RD;
      S_F_DEC: begin
        if (prev_join) begin
          state_nxt = next_join ? S_SH_RD : S_DONE;
        end else if (next_join) begin
          state_nxt = S_DONE;
        end else if (not_full) begin
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_RD:  state_nxt = shift_more ? S_SH_WR : S_DONE;
      S_SH_WR:  state_nxt = S_SH_RD;
      S_INS_RD: state_nxt = ins_more ? S_INS_WR : S_DONE;
      S_INS_WR: state_nxt = S_INS_RD;
      S_DONE:   state_nxt = res_take ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    peak_nxt       = peak_r;
    pos_nxt        = pos_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    has_prev_nxt   = has_prev_r;
    has_next_nxt   = has_next_r;
    total_nxt      = total_r;
    lost_cnt_nxt   = lost_cnt_r;
    lost_bytes_nxt = lost_bytes_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    mem_wr.we      = 1'b0;
    mem_wr.wdata   = mem_rdata;
    mem_waddr      = idx_r[IW-1:0];
    mem_raddr      = idx_r[IW-1:0];
    req_ready      = 1'b0;
    res_valid      = 1'b0;
    case (state_r)
      S_IDLE: begin
        req_ready      = 1'b1;
        req_nxt        = req;
        idx_nxt        = '0;
        has_prev_nxt   = 1'b0;
        has_next_nxt   = 1'b0;
        res_addr_nxt   = 32'd0;
        res_status_nxt = ST_OK;
      end
      S_A_RD: begin
        if (at_end) begin
          res_status_nxt = ST_NOFIT;
        end
      end
      S_A_CHK: begin
        if (fit) begin
          res_addr_nxt       = mem_rdata.start;
          total_nxt          = total_r - req_r.size;
          // emptied region is dropped by the shift-down loop
          mem_wr.we          = new_len != 32'd0;
          mem_wr.wdata.start = mem_rdata.start + req_r.size;
          mem_wr.wdata.len   = new_len;
        end else begin
          idx_nxt = idx_inc[CW-1:0];
        end
      end
      S_F_CHK: begin
        if (beyond) begin
          next_nxt     = mem_rdata;
          has_next_nxt = 1'b1;
        end else begin
          prev_nxt     = mem_rdata;
          has_prev_nxt = 1'b1;
          idx_nxt      = idx_inc[CW-1:0];
        end
      end
      S_F_DEC: begin
        if (prev_join) begin
          total_nxt          = total_r + req_r.size;
          mem_wr.we          = 1'b1;
          mem_waddr          = IW'(idx_r - 1'b1);
          mem_wr.wdata.start = prev_r.start;
          mem_wr.wdata.len   = prev_r.len + req_r.size + (next_join ? next_r.len : 32'd0);
        end else if (next_join) begin
          total_nxt          = total_r + req_r.size;
          mem_wr.we          = 1'b1;
          mem_wr.wdata.start = req_r.addr;
          mem_wr.wdata.len   = next_r.len + req_r.size;
        end else if (not_full) begin
          total_nxt = total_r + req_r.size;
          pos_nxt   = idx_r[IW-1:0];
          idx_nxt   = cnt_r;
        end else begin
          lost_cnt_nxt   = lost_cnt_r + 32'd1;
          lost_bytes_nxt = lost_bytes_r + req_r.size;
          res_status_nxt = ST_LOST;
        end
      end
      S_SH_RD: begin
        mem_raddr = idx_inc[IW-1:0];
        if (!shift_more) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_SH_WR: begin
        mem_wr.we = 1'b1;
        idx_nxt   = idx_inc[CW-1:0];
      end
      S_INS_RD: begin
        mem_raddr = IW'(idx_r - 1'b1);
        if (!ins_more) begin
          mem_wr.we          = 1'b1;
          mem_waddr          = pos_r;
          mem_wr.wdata.start = req_r.addr;
          mem_wr.wdata.len   = req_r.size;
          cnt_nxt            = cnt_inc;
          if (peak_r < cnt_inc) begin
            peak_nxt = cnt_inc;
          end
        end
      end
      S_INS_WR: begin
        mem_wr.we = 1'b1;
        idx_nxt   = idx_r - 1'b1;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      peak_r       <= '0;
      total_r      <= 32'd0;
      lost_cnt_r   <= 32'd0;
      lost_bytes_r <= 32'd0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      peak_r       <= peak_nxt;
      total_r      <= total_nxt;
      lost_cnt_r   <= lost_cnt_nxt;
      lost_bytes_r <= lost_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    has_prev_r   <= has_prev_nxt;
    has_next_r   <= has_next_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  assign res.alloc_addr   = res_addr_r;
  assign res.status       = res_status_r;
  assign res.total_free   = total_r;
  assign res.peak_entries = 9'(peak_r);
  assign res.lost_count   = lost_cnt_r;
  assign res.lost_bytes   = lost_bytes_r;
  assign entry_count      = cnt_r;

endmodule

/* src/sorted_free_list_allocator.sv */
// First-fit allocator over a table of free regions kept sorted by address.
// in_ channel: one request per transfer, kind selects allocate or free.
// out_ channel: one result per request with granted address, status,
// total free bytes, peak entry count and the lost-free counters.
// A request walks the table through one region memory with one registered
// read port and one write port, then may shift entries up or down.
// Entries visited plus entries moved never exceed the table size.
// One request is in flight at a time: in_ready is high only while the
// sequencer is idle.
// Results go to an output register; when the receiver stalls the next
// request may still be taken and worked on, and its result waits in the
// sequencer until the output register frees up.
// Reset empties the table (entry count zero) and clears the peak, total
// and lost counters; no memory clearing pass is needed, so the block is
// ready as soon as reset is released.
module sorted_free_list_allocator #(
  parameter int TABLE_ENTRIES = sfla_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfla_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sfla_pkg::out_item_t out_data
);
  import sfla_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic          res_valid, res_take;
  out_item_t     res;
  logic [CW-1:0] entry_count;
  mem_wr_t       mem_wr;
  logic [IW-1:0] mem_waddr, mem_raddr;
  region_t       mem_rdata;
  logic          out_valid_r;
  out_item_t     out_data_r;

  sfla_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_ready  (in_ready),
    .req        (in_data),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .entry_count(entry_count),
    .mem_wr     (mem_wr),
    .mem_waddr  (mem_waddr),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  sfla_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mem (
    .clk  (clk),
    .wr   (mem_wr),
    .waddr(mem_waddr),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_take) |=> out_valid)
    else $error("finished result not registered");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_NOFIT ||
                   out_data.status == ST_LOST))
    else $error("bad status code");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

endmodule

/* tb/sorted_free_list_allocator_checker.sv */
`timescale 1ns / 1ps

module sorted_free_list_allocator_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sfla_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sfla_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import sfla_pkg::*;

  localparam int DEPTH = TABLE_ENTRIES_DEF;

  logic [31:0] reg_start [DEPTH];
  logic [31:0] reg_len   [DEPTH];
  int          used;
  logic [8:0]  peak;
  logic [31:0] lost_n;
  logic [31:0] lost_sum;
  out_item_t   result_q[$];

  function automatic void drop_entry(input int at);
    for (int k = at; k + 1 < used; k++) begin
      reg_start[k] = reg_start[k + 1];
      reg_len[k]   = reg_len[k + 1];
    end
    used--;
  endfunction

  function automatic out_item_t compute_result(input in_item_t req);
    out_item_t r;
    int i;
    logic [31:0] tot;
    logic [31:0] end_addr;
    r = '0;
    r.status = ST_OK;
    if (req.kind == KIND_ALLOC) begin
      r.status = ST_NOFIT;
      for (i = 0; i < used; i++) begin
        if (reg_len[i] >= req.size) begin
          r.alloc_addr = reg_start[i];
          reg_start[i] += req.size;
          reg_len[i] -= req.size;
          if (reg_len[i] == 0) drop_entry(i);
          r.status = ST_OK;
          break;
        end
      end
    end else begin
      end_addr = req.addr + req.size;
      for (i = 0; i < used; i++) if (reg_start[i] > req.addr) break;
      if (i > 0 && reg_start[i - 1] + reg_len[i - 1] == req.addr) begin
        reg_len[i - 1] += req.size;
        if (i < used && end_addr == reg_start[i]) begin
          reg_len[i - 1] += reg_len[i];
          drop_entry(i);
        end
      end else if (i < used && end_addr == reg_start[i]) begin
        reg_start[i] = req.addr;
        reg_len[i] += req.size;
      end else if (used < DEPTH) begin
        for (int k = used; k > i; k--) begin
          reg_start[k] = reg_start[k - 1];
          reg_len[k]   = reg_len[k - 1];
        end
        reg_start[i] = req.addr;
        reg_len[i]   = req.size;
        used++;
        if (peak < used) peak = 9'(used);
      end else begin
        lost_n++;
        lost_sum += req.size;
        r.status = ST_LOST;
      end
    end
    tot = '0;
    for (i = 0; i < used; i++) tot += reg_len[i];
    r.total_free   = tot;
    r.peak_entries = peak;
    r.lost_count   = lost_n;
    r.lost_bytes   = lost_sum;
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      used <= 0;
      peak <= '0;
      lost_n <= '0;
      lost_sum <= '0;
      fail_count <= 0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %p", out_data);
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r !== out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p got %p", exp_r, out_data);
          end
        end
      end
      if (in_valid && in_ready) result_q.push_back(compute_result(in_data));
    end
  end
endmodule

/* tb/sorted_free_list_allocator_tb.sv */
`timescale 1ns / 1ps

module sorted_free_list_allocator_tb;
  import sfla_pkg::*;

  localparam int WATCHDOG = 40000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int idle_cycles = 0;
  logic [31:0] next_addr = 32'h1000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_free_list_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  sorted_free_list_allocator_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stall plus one long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_off <= 3000;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(input logic kind, input logic [31:0] addr, input logic [31:0] size);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: kind, addr: addr, size: size};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // mostly well-formed traffic around a moving address pool, some noise
  task automatic random_item();
    logic [31:0] a;
    logic [31:0] s;
    int pick;
    pick = $urandom_range(99);
    s = $urandom_range(1, 64);
    if (pick < 40) begin
      send(KIND_ALLOC, $urandom, s);
    end else if (pick < 85) begin
      a = next_addr + ($urandom_range(3) == 0 ? 0 : $urandom_range(1, 32));
      next_addr = a + s;
      send(KIND_FREE, a, s);
    end else if (pick < 95) begin
      send(1'($urandom_range(1)), $urandom, $urandom);
    end else begin
      send(KIND_FREE, next_addr - $urandom_range(200), $urandom_range(0, 16));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    send(KIND_ALLOC, 32'h0, 32'h0);
    send(KIND_ALLOC, 32'hFFFF_FFFF, 32'd10);
    send(KIND_FREE, 32'h0, 32'd16);
    send(KIND_ALLOC, 32'h0, 32'd4);
    send(KIND_ALLOC, 32'h0, 32'd0);
    send(KIND_FREE, 32'h0, 32'd4);
    send(KIND_FREE, 32'h40, 32'd0);
    send(KIND_ALLOC, 32'h0, 32'd0);
    send(KIND_ALLOC, 32'h0, 32'd0);
    send(KIND_FREE, 32'h20, 32'h10);
    send(KIND_FREE, 32'h10, 32'h10);
    send(KIND_FREE, 32'h10, 32'h8);
    send(KIND_FREE, 32'hFFFF_FFF0, 32'h10);
    send(KIND_FREE, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send(KIND_ALLOC, 32'h0, 32'hFFFF_FFFF);
    send(KIND_ALLOC, 32'h0, 32'h1000_0000);
    send(KIND_FREE, 32'h8000_0000, 32'h8000_0000);
    send(KIND_ALLOC, 32'h0, 32'hFFFF_FFFF);
    send(KIND_ALLOC, 32'h0, 32'h7FFF_FFFF);

    // fill the table past full so frees get lost
    for (int i = 0; i < 270; i++)
      send(KIND_FREE, 32'h0100_0000 + i * 64, 32'd8);
    for (int i = 0; i < 30; i++) send(KIND_ALLOC, 32'h0, 32'd8);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 59; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 59; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      if (ph == 2) hold_go = 1'b1;
      for (int n = 0; n < 210; n++) random_item();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
